FILE: hdl/pspr_pkg.sv
// Shared types and constants for the pedal sensor plausibility and ramp block.
// No dependencies; imported by the top level and its checker.
package pspr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int PCT_W     = 7;
    localparam int LIMIT_W   = 16;
    localparam int STEP_W    = 8;
    localparam int LEVEL_W   = SAMPLE_W + 1;   // half-unit torque level
    localparam int PROD_W    = 23;             // holds 100 * diff and pct * max
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [TIME_W-1:0]    stamp_t;
    typedef logic [LEVEL_W-1:0]   level_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_MISMATCH_PCT = 2'd0;
    localparam cfg_idx_t REG_FAULT_TIME   = 2'd1;
    localparam cfg_idx_t REG_RAMP_STEP    = 2'd2;

    // Register reset values
    localparam logic [PCT_W-1:0]   PCT_RST   = 7'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd100;
    localparam logic [STEP_W-1:0]  STEP_RST  = 8'd1;

endpackage

FILE: hdl/pedal_sensor_plausibility_ramp_unit.sv
// Top level of the pedal sensor plausibility check with torque ramp.
// Depends on pspr_pkg for widths, register indexes and reset values.

// Each transfer on the s_ channel carries two redundant pedal sensor samples
// and a millisecond timestamp; each produces exactly one transfer on the m_
// channel with the torque command and a fault flag. The block takes one item
// per clock cycle when the m_ side keeps m_ready high. An item sits in the
// input register after its input transfer and moves to the result register
// at the first edge at which that register is free or being emptied, which
// raises m_valid; the result transfer can follow from there.
// The figure of one item per cycle is set by the state update loop:
// the mismatch compare (a 7 x 16 multiply against 100 times the difference),
// the elapsed-time compare and the ramp add all settle in the one cycle in
// which an item moves from the input register to the result register, and
// the mismatch-run and torque-level state is written at that same edge. When
// the result register is full and not taken, the input register holds its
// item and s_ready drops only once both are occupied. Configuration writes
// land at once through cfg_wen; write them only while no item is in flight.
// A sensor pair is a mismatch when 100 * |a - b| > mismatch_percent * max(a, b).
// A mismatch run that outlasts fault_time_ms (modulo 2^32 elapsed time) gives
// fault with zero torque and clears the level; otherwise the half-unit level
// moves toward twice the larger sample by at most ramp_step and its integer
// part is sent out.
module pedal_sensor_plausibility_ramp_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wen,
    input  pspr_pkg::cfg_idx_t   cfg_index,
    input  pspr_pkg::cfg_dat_t   cfg_wdata,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pspr_pkg::sample_t    s_sensor_a,
    input  pspr_pkg::sample_t    s_sensor_b,
    input  pspr_pkg::stamp_t     s_now_ms,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output pspr_pkg::sample_t    m_torque_out,
    output logic                 m_fault
);
    import pspr_pkg::*;

    // configuration registers
    logic [PCT_W-1:0]   pct_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [STEP_W-1:0]  step_reg;

    // input register: larger sample and difference are formed on the way in
    logic    in_valid_reg;
    sample_t hi_reg;
    sample_t diff_reg;
    stamp_t  now_reg;

    // block state
    logic    active_reg;
    stamp_t  start_reg;
    level_t  level_reg;

    // result register
    logic    out_valid_reg;
    sample_t torque_reg;
    logic    fault_reg;

    logic    advance;
    logic    s_fire;
    sample_t hi_next;
    sample_t diff_next;

    prod_t   diff_x100;
    prod_t   allowed;
    logic    mismatch;
    stamp_t  start_eff;
    stamp_t  elapsed;
    logic    fault_now;
    level_t  target;
    level_t  room;
    level_t  step_ext;
    level_t  delta;
    level_t  level_next;

    // -------------------------------------------------------------------
    // Handshake: advance the input item whenever the result slot is free
    // or being emptied; accept a new transfer whenever the input register
    // is empty or advancing.
    // -------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign m_valid      = out_valid_reg;
    assign m_torque_out = torque_reg;
    assign m_fault      = fault_reg;

    // -------------------------------------------------------------------
    // Input side: larger sample and absolute difference
    // -------------------------------------------------------------------
    always_comb begin
        if (s_sensor_a > s_sensor_b) begin
            hi_next   = s_sensor_a;
            diff_next = s_sensor_a - s_sensor_b;
        end else begin
            hi_next   = s_sensor_b;
            diff_next = s_sensor_b - s_sensor_a;
        end
    end

    // -------------------------------------------------------------------
    // Plausibility check and ramp
    // -------------------------------------------------------------------
    always_comb begin
        // 100 * diff as shifts and adds: 64 + 32 + 4
        diff_x100 = (PROD_W'(diff_reg) << 6) + (PROD_W'(diff_reg) << 5)
                  + (PROD_W'(diff_reg) << 2);
        allowed   = PROD_W'(pct_reg) * PROD_W'(hi_reg);
        mismatch  = diff_x100 > allowed;

        // a fresh run starts at this sample, so its elapsed time is zero
        start_eff = active_reg ? start_reg : now_reg;
        elapsed   = now_reg - start_eff;
        fault_now = mismatch && (elapsed > TIME_W'(limit_reg));

        target    = {hi_reg, 1'b0};
        step_ext  = LEVEL_W'(step_reg);
        room      = (level_reg < target) ? (target - level_reg) : (level_reg - target);
        delta     = (step_ext < room) ? step_ext : room;

        if (fault_now) begin
            level_next = '0;
        end else if (level_reg < target) begin
            level_next = level_reg + delta;
        end else begin
            level_next = level_reg - delta;   // delta is zero on target
        end
    end

    // -------------------------------------------------------------------
    // Registers
    // -------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg       <= PCT_RST;
            limit_reg     <= LIMIT_RST;
            step_reg      <= STEP_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            start_reg     <= '0;
            level_reg     <= '0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_MISMATCH_PCT: pct_reg   <= cfg_wdata[PCT_W-1:0];
                    REG_FAULT_TIME:   limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    REG_RAMP_STEP:    step_reg  <= cfg_wdata[STEP_W-1:0];
                    default: ;        // unused index: drop the write
                endcase
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                active_reg    <= mismatch;
                if (mismatch && !active_reg) begin
                    start_reg <= now_reg;
                end
                level_reg     <= level_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hi_reg   <= hi_next;
            diff_reg <= diff_next;
            now_reg  <= s_now_ms;
        end
        if (advance) begin
            // level is zero on fault, so its integer part is the torque
            torque_reg <= level_next[LEVEL_W-1:1];
            fault_reg  <= fault_now;
        end
    end

endmodule

FILE: hdl/pspr_checker.sv
// Port-level checker for pedal_sensor_plausibility_ramp_unit, with its bind.
// Depends on pspr_pkg for port types.
module pspr_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input pspr_pkg::sample_t    m_torque_out,
    input logic                 m_fault
);
    import pspr_pkg::*;

    // a fault result always commands zero torque
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault |-> m_torque_out == '0)
        else $error("fault result with non-zero torque");

    // a free result side never stalls the input side
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while results are taken");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_torque_out) && $stable(m_fault))
        else $error("stalled result changed");

endmodule

bind pedal_sensor_plausibility_ramp_unit pspr_checker u_pspr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_torque_out (m_torque_out),
    .m_fault      (m_fault)
);
